/* src/cpu_alu_with_flags_unit_macros.svh */
// Assertion macros used by the ALU top-level design file.
`ifndef CPU_ALU_WITH_FLAGS_UNIT_MACROS_SVH
`define CPU_ALU_WITH_FLAGS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CAWF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CAWF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CAWF_ASSERT(lbl, prop, msg)
`define CAWF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/cawf_pkg.sv */
package cawf_pkg;

    localparam int OpWidth   = 5;
    localparam int WordWidth = 16;
    localparam int ByteWidth = 8;
    localparam int IdxWidth  = 3;
    localparam int InWidth   = 40;
    localparam int OutWidth  = 24;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CP    = 5'd7,
        OP_INC8  = 5'd8,
        OP_DEC8  = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RL    = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SWAP  = 5'd16,
        OP_SRL   = 5'd17,
        OP_BIT   = 5'd18,
        OP_RES   = 5'd19,
        OP_SET   = 5'd20,
        OP_ADD16 = 5'd21,
        OP_INC16 = 5'd22,
        OP_DEC16 = 5'd23
    } op_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [IdxWidth-1:0]  bit_index;
        logic [WordWidth-1:0] operand_y;
        logic [WordWidth-1:0] operand_x;
        logic [OpWidth-1:0]   req_type;
    } req_t;

    typedef struct packed {
        logic [WordWidth-1:0] value;
        logic                 writes_back;
        flags_t               flags;
    } res_t;

endpackage

/* src/cpu_alu_with_flags_unit.sv */
// An accepted request waits in the input register until the output register is free,
// then its result is registered there. Throughput: one request per cycle while the
// output is not stalled; the stored flags are registered from the ALU and feed back to it.
// An empty input register takes a request while a finished result waits.
// Reset clears the flags and empties the input stage and the output stage.
`include "cpu_alu_with_flags_unit_macros.svh"

module cpu_alu_with_flags_unit
    import cawf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // req_type[4:0], operand_x[20:5], operand_y[36:21], bit_index[39:37].
    input  logic [InWidth-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result_value[15:0], writes_back[16], zero_out[17], subtract_out[18],
    // half_carry_out[19], carry_out[20], zero pad[23:21].
    output logic [OutWidth-1:0] m_axis_tdata
);

    req_t                in_data_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    flags_t              flag_reg;
    flags_t              flag_next;
    logic [OutWidth-1:0] out_data_reg;
    logic [OutWidth-1:0] out_data_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;
    logic                adv;
    res_t                alu_res;

    cawf_alu u_alu (
        .req      (in_data_reg),
        .flags_in (flag_reg),
        .res      (alu_res)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign adv           = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        flag_next      = flag_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (adv)
        begin
            in_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            flag_next      = alu_res.flags;
            out_data_next  = {3'b000, alu_res.flags.c, alu_res.flags.h, alu_res.flags.n,
                              alu_res.flags.z, alu_res.writes_back, alu_res.value};
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `CAWF_ASSERT(a_take_fills_input, (s_axis_tvalid && s_axis_tready) |=> in_valid_reg,
                 "accepted request did not reach the input stage")
    `CAWF_ASSERT(a_flags_match_result, adv |=> (flag_reg == flags_t'({out_data_reg[17],
                 out_data_reg[18], out_data_reg[19], out_data_reg[20]})),
                 "stored flags differ from the flags of the last result")
    `CAWF_ASSERT(a_flags_hold, !adv |=> $stable(flag_reg),
                 "stored flags changed without a result")
    `CAWF_ASSERT(a_result_from_stage, (out_valid_reg && !$past(out_valid_reg)) |-> $past(adv),
                 "result appeared without an input request")

endmodule

/* src/cawf_alu.sv */
module cawf_alu
    import cawf_pkg::*;
(
    input  req_t   req,
    input  flags_t flags_in,
    output res_t   res
);

    logic [ByteWidth-1:0] a;
    logic [ByteWidth-1:0] b;
    logic                 t;
    logic [ByteWidth:0]   sum9;
    logic [4:0]           hsum;
    logic [ByteWidth:0]   diff9;
    logic [4:0]           hdiff;
    logic [WordWidth:0]   sum17;
    logic [12:0]          sum13;
    logic [ByteWidth-1:0] r8;
    logic [ByteWidth-1:0] mask;

    always_comb
    begin
        a     = req.operand_x[ByteWidth-1:0];
        b     = req.operand_y[ByteWidth-1:0];
        t     = 1'b0;
        if (req.req_type == OP_ADC || req.req_type == OP_SBC)
        begin
            t = flags_in.c;
        end
        sum9  = {1'b0, a} + {1'b0, b} + {8'd0, t};
        hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
        diff9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
        hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
        sum17 = {1'b0, req.operand_x} + {1'b0, req.operand_y};
        sum13 = {1'b0, req.operand_x[11:0]} + {1'b0, req.operand_y[11:0]};
        mask  = 8'(1) << req.bit_index;
        r8    = a;

        res.value       = req.operand_x;
        res.writes_back = 1'b1;
        res.flags       = flags_in;

        case (op_t'(req.req_type))
            OP_ADD, OP_ADC:
            begin
                r8        = sum9[ByteWidth-1:0];
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: hsum[4], c: sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r8        = diff9[ByteWidth-1:0];
                res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: hdiff[4], c: diff9[8]};
                if (req.req_type == OP_CP)
                begin
                    r8              = a;
                    res.writes_back = 1'b0;
                end
            end
            OP_AND:
            begin
                r8        = a & b;
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_OR:
            begin
                r8        = a | b;
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_XOR:
            begin
                r8        = a ^ b;
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC8:
            begin
                r8        = a + 8'd1;
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: flags_in.c};
            end
            OP_DEC8:
            begin
                r8        = a - 8'd1;
                res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: flags_in.c};
            end
            OP_RLC:
            begin
                r8        = {a[6:0], a[7]};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_RRC:
            begin
                r8        = {a[0], a[7:1]};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_RL:
            begin
                r8        = {a[6:0], flags_in.c};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_RR:
            begin
                r8        = {flags_in.c, a[7:1]};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_SLA:
            begin
                r8        = {a[6:0], 1'b0};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_SRA:
            begin
                r8        = {a[7], a[7:1]};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_SWAP:
            begin
                r8        = {a[3:0], a[7:4]};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_SRL:
            begin
                r8        = {1'b0, a[7:1]};
                res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_BIT:
            begin
                r8              = a;
                res.writes_back = 1'b0;
                res.flags       = '{z: ((a & mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags_in.c};
            end
            OP_RES:
            begin
                r8 = a & ~mask;
            end
            OP_SET:
            begin
                r8 = a | mask;
            end
            OP_ADD16:
            begin
                res.flags = '{z: flags_in.z, n: 1'b0, h: sum13[12], c: sum17[WordWidth]};
            end
            OP_INC16, OP_DEC16:
            begin
                r8 = a;
            end
            default:
            begin
                res.writes_back = 1'b0;
            end
        endcase

        case (op_t'(req.req_type))
            OP_ADD16:
            begin
                res.value = sum17[WordWidth-1:0];
            end
            OP_INC16:
            begin
                res.value = req.operand_x + 16'd1;
            end
            OP_DEC16:
            begin
                res.value = req.operand_x - 16'd1;
            end
            default:
            begin
                if (req.req_type <= OP_SET)
                begin
                    res.value = {8'd0, r8};
                end
            end
        endcase
    end

endmodule
